[rtl/ilid_pkg.sv]
package ilid_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 16;
  localparam int OP_W         = 3;
  localparam int CNT_OUT_W    = 7;
  localparam int SLOT_W       = 12;

  typedef enum logic [OP_W-1:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
  } cell_cmd_t;

endpackage

[rtl/ilid_cell.sv]
module ilid_cell
  import ilid_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] q_o,
  output logic [DATA_W-1:0] rd_o
);

  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(IDX);

  logic [DATA_W-1:0] q_q;
  logic [DATA_W-1:0] q_d;

  always_comb begin
    q_d = q_q;
    if (cmd_i.ins) begin
      if (MyIdx == cmd_i.slot) begin
        q_d = cmd_i.data;
      end else if (MyIdx > cmd_i.slot) begin
        q_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (MyIdx >= cmd_i.slot) begin
        q_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o  = q_q;
  assign rd_o = (MyIdx == cmd_i.slot) ? q_q : '0;

endmodule

[rtl/indexed_list_insert_delete_get.sv]
// Requests register on acceptance; each result then registers with valid_o.
// Throughput: one request per cycle; busy_o never asserts.
// Each request is decoded in the cycle after acceptance and applied to the
// cell chain; entries at and above the slot shift in parallel in that cycle.
// Reset clears the entry count and the pipeline valids; entries stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_list_insert_delete_get
  import ilid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [POS_W-1:0]  position_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [1:0]               status_o,
  output logic [CNT_OUT_W-1:0]     count_out_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic              req_vld_q;
  logic [OP_W-1:0]   req_op_q;
  logic [POS_W-1:0]  req_pos_q;
  logic [DATA_W-1:0] req_data_q;

  logic [CW-1:0]     count_q, count_d;

  logic                 valid_q;
  logic [DATA_W-1:0]    data_q, data_d;
  status_e              status_q, status_d;
  logic [CNT_OUT_W-1:0] cnt_out_q;

  cell_cmd_t         cmd;
  logic              rd_en;
  logic [DATA_W-1:0] rd_or;

  logic              pos_neg;
  logic [POS_W-2:0]  pos_mag;
  logic              pos_lt_cnt;
  logic              pos_gt_cnt;
  logic              full;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  logic [DATA_W-1:0] cell_q  [CAPACITY];
  logic [DATA_W-1:0] cell_rd [CAPACITY];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      count_q   <= '0;
      valid_q   <= 1'b0;
    end else begin
      req_vld_q <= start_i;
      count_q   <= count_d;
      valid_q   <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_op_q   <= opcode_i;
      req_pos_q  <= position_i;
      req_data_q <= data_in_i;
    end
    data_q    <= data_d;
    status_q  <= status_d;
    cnt_out_q <= cnt_ext[CNT_OUT_W-1:0];
  end

  assign pos_neg    = req_pos_q[POS_W-1];
  assign pos_mag    = req_pos_q[POS_W-2:0];
  assign pos_lt_cnt = !pos_neg && (pos_mag < (POS_W-1)'(count_q));
  assign pos_gt_cnt = !pos_neg && (pos_mag > (POS_W-1)'(count_q));
  assign full       = (count_q == CW'(CAPACITY));
  assign cnt_ext    = {{CNT_OUT_W{1'b0}}, count_d};

  always_comb begin
    cmd      = '0;
    cmd.data = req_data_q;
    status_d = ST_DONE;
    rd_en    = 1'b0;
    if (req_vld_q) begin
      case (req_op_q)
        OP_READ: begin
          if (pos_lt_cnt) begin
            rd_en    = 1'b1;
            cmd.slot = SLOT_W'(pos_mag);
          end else begin
            status_d = ST_MISS;
          end
        end
        OP_INS_HEAD: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
          end
        end
        OP_INS_TAIL: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins  = 1'b1;
            cmd.slot = SLOT_W'(count_q);
          end
        end
        OP_INS_AT: begin
          if (pos_gt_cnt) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.ins  = 1'b1;
            cmd.slot = pos_neg ? '0 : SLOT_W'(pos_mag);
          end
        end
        OP_DELETE: begin
          if (pos_lt_cnt) begin
            cmd.del  = 1'b1;
            cmd.slot = SLOT_W'(pos_mag);
          end else begin
            status_d = ST_RANGE;
          end
        end
        default: begin
          status_d = ST_RANGE;
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd.del) begin
      count_d = count_q - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ilid_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i ((i == 0) ? cmd.data : cell_q[(i == 0) ? 0 : i - 1]),
      .right_i((i == CAPACITY - 1) ? '0 : cell_q[(i == CAPACITY - 1) ? i : i + 1]),
      .q_o    (cell_q[i]),
      .rd_o   (cell_rd[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    if (rd_en) begin
      data_d = rd_or;
    end else if (status_d == ST_MISS) begin
      data_d = '1;
    end else begin
      data_d = '0;
    end
  end

  assign valid_o     = valid_q;
  assign data_out_o  = data_q;
  assign status_o    = status_q;
  assign count_out_o = cnt_out_q;

endmodule

[test/ilid_checker.sv]
module ilid_checker
  import ilid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_start_i,
  input  logic                     req_busy_i,
  input  logic [OP_W-1:0]          req_op_i,
  input  logic signed [POS_W-1:0]  req_pos_i,
  input  logic signed [DATA_W-1:0] req_value_i,
  input  logic                     rsp_valid_i,
  input  logic signed [DATA_W-1:0] rsp_data_i,
  input  logic [1:0]               rsp_status_i,
  input  logic [CNT_OUT_W-1:0]     rsp_count_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       list_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [CNT_OUT_W-1:0]     count;
  } list_result_t;

  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int                       list_len = 0;
  list_result_t             expected_q [$];
  list_result_t             want;
  int                       fails = 0;
  int                       outstanding = 0;

  assign fail_count_o = fails;
  assign pending_o    = outstanding;
  assign list_count_o = list_len;

  function automatic status_e insert_entry(int slot, logic signed [DATA_W-1:0] value);
    if (list_len >= CAPACITY || slot > list_len) return ST_FULL;
    for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
    list_mem[slot] = value;
    list_len++;
    return ST_DONE;
  endfunction

  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                  logic signed [POS_W-1:0] pos,
                                                  logic signed [DATA_W-1:0] value);
    list_result_t r;
    int p;
    p = pos;
    r.data = '0;
    r.status = ST_DONE;
    case (op)
      OP_READ: begin
        if (p < 0 || p >= list_len) begin
          r.data = -1;
          r.status = ST_MISS;
        end else begin
          r.data = list_mem[p];
        end
      end
      OP_INS_HEAD: r.status = insert_entry(0, value);
      OP_INS_TAIL: r.status = insert_entry(list_len, value);
      OP_INS_AT: begin
        if (p < 0) r.status = insert_entry(0, value);
        else if (p > list_len) r.status = ST_RANGE;
        else r.status = insert_entry(p, value);
      end
      OP_DELETE: begin
        if (p < 0 || p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = list_len[CNT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      list_len = 0;
    end else begin
      if (rsp_valid_i) begin
        if (expected_q.size() == 0) begin
          $error("result strobe with no request outstanding");
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_data_i !== want.data) begin
            $error("data_out: expected %0d, got %0d", want.data, rsp_data_i);
            fails++;
          end
          if (rsp_status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_status_i);
            fails++;
          end
          if (rsp_count_i !== want.count) begin
            $error("count_out: expected %0d, got %0d", want.count, rsp_count_i);
            fails++;
          end
        end
      end
      if (req_start_i && !req_busy_i)
        expected_q.push_back(apply_list_op(req_op_i, req_pos_i, req_value_i));
    end
    outstanding = expected_q.size();
  end

endmodule

[test/tb_indexed_list_insert_delete_get.sv]
module tb_indexed_list_insert_delete_get;
  import ilid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = {OP_W{1'b1}};
  localparam int RANDOM_REQS = 1650;
  localparam int PHASE_LEN   = 110;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} traffic_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [OP_W-1:0]          opcode_i = '0;
  logic signed [POS_W-1:0]  position_i = '0;
  logic signed [DATA_W-1:0] data_in_i = '0;
  logic                     valid_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [1:0]               status_o;
  logic [CNT_OUT_W-1:0]     count_out_o;

  int fail_count;
  int pending;
  int list_count;

  indexed_list_insert_delete_get dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .data_in_i  (data_in_i),
    .valid_o    (valid_o),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .count_out_o(count_out_o)
  );

  ilid_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_start_i (start_i),
    .req_busy_i  (busy_o),
    .req_op_i    (opcode_i),
    .req_pos_i   (position_i),
    .req_value_i (data_in_i),
    .rsp_valid_i (valid_o),
    .rsp_data_i  (data_out_o),
    .rsp_status_i(status_o),
    .rsp_count_i (count_out_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .list_count_o(list_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #200_000;
    $display("indexed_list_insert_delete_get test failed");
    $finish;
  end

  task automatic send_request(input logic [OP_W-1:0] op, input int pos,
                              input logic [DATA_W-1:0] value);
    logic taken;
    start_i    <= 1'b1;
    opcode_i   <= op;
    position_i <= pos[POS_W-1:0];
    data_in_i  <= value;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic idle(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits until every outstanding request has produced its result.
  task automatic drain_results();
    idle(1);
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic int pick_position(int cnt);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 16'hFFFF) - 32768;
      1: return -int'($urandom_range(1, 3));
      2: return cnt;
      3: return cnt + $urandom_range(1, 3);
      default: return (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_insert();
    case ($urandom_range(0, 2))
      0: return OP_INS_HEAD;
      1: return OP_INS_TAIL;
      default: return OP_INS_AT;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(traffic_mode_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    case (mode)
      MODE_GROW: begin
        if (roll < 85) return pick_insert();
        if (roll < 95) return OP_READ;
        return OP_DELETE;
      end
      MODE_SHRINK: begin
        if (roll < 60) return OP_DELETE;
        if (roll < 80) return OP_READ;
        return pick_insert();
      end
      default: begin
        if (roll < 35) return pick_insert();
        if (roll < 70) return OP_READ;
        return OP_DELETE;
      end
    endcase
  endfunction

  initial begin
    int burst_left;
    int settle;
    traffic_mode_e mode;

    burst_left = 0;
    mode = MODE_GROW;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list and position boundary corner cases
    send_request(OP_READ, 0, '0);
    send_request(OP_READ, -1, '0);
    send_request(OP_DELETE, 0, '0);
    send_request(OP_INS_AT, 1, 32'h1234_5678);
    send_request(OP_INS_AT, 0, 32'h8000_0000);
    send_request(OP_READ, 0, '0);
    send_request(OP_READ, 1, '0);
    send_request(OP_INS_AT, -32768, 32'h7FFF_FFFF);
    send_request(OP_INS_AT, 2, '1);
    send_request(OP_INS_HEAD, 0, 32'h0000_0001);
    send_request(OP_INS_TAIL, 0, 32'hFFFF_FFFE);
    send_request(OP_INS_AT, 2, 32'hA5A5_5A5A);
    send_request(OP_INS_AT, 32767, 32'h5555_5555);
    send_request(OP_READ, 2, '0);
    send_request(OP_READ, 32767, '0);
    send_request(OP_READ, -32768, '0);
    send_request(OP_DELETE, -32768, '0);
    send_request(OP_DELETE, 6, '0);
    send_request(OP_DELETE, 5, '0);
    send_request(OP_DELETE, 0, '0);
    send_request(OP_READ, 4, '0);
    for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
      send_request(c[OP_W-1:0], 0, '1);
    drain_results();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % PHASE_LEN == 0) begin
        if (n > 0 && (n / PHASE_LEN) % 4 == 0) drain_results();
        mode = (n < 2 * PHASE_LEN) ? MODE_GROW : traffic_mode_e'($urandom_range(0, 2));
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
      end
      burst_left--;
      send_request(pick_op(mode), pick_position(list_count), pick_value());
    end

    idle(1);
    settle = 0;
    while (pending != 0 && settle < 1000) begin
      @(negedge clk_i);
      settle++;
    end
    repeat (4) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("indexed_list_insert_delete_get test passed");
    end else begin
      if (pending != 0) $error("%0d requests never produced a result", pending);
      $display("indexed_list_insert_delete_get test failed");
    end
    $finish;
  end

endmodule
